// File: hdl/bsirq_pkg.sv
// Shared types and constants for the bank switch / cycle IRQ counter block.
// No dependencies; imported by the channel interfaces and the top level.
package bsirq_pkg;

	// Payload widths
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned BANK_W = 8;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned CTL_W  = 3;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_AND_MASK  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_OR_OFFSET = 1'd1;
	localparam logic [BANK_W-1:0] BANK_AND_MASK_RST  = 8'hFF;
	localparam logic [BANK_W-1:0] BANK_OR_OFFSET_RST = 8'h00;

	// Item kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Control bit positions
	localparam int unsigned CTL_ACK_ENABLE = 0;
	localparam int unsigned CTL_ENABLE     = 1;
	localparam int unsigned CTL_BYTE_MODE  = 2;

	// Fixed last bank and counter terminal values
	localparam logic [BANK_W-1:0] LAST_BANK     = 8'hFF;
	localparam logic [7:0]        BYTE_TERMINAL = 8'hFF;
	localparam logic [CNT_W-1:0]  WORD_TERMINAL = 16'hFFFF;

	// Register select, address bits 14..12
	typedef enum logic [2:0] {
		SEL_NIB0   = 3'd0,
		SEL_NIB1   = 3'd1,
		SEL_NIB2   = 3'd2,
		SEL_NIB3   = 3'd3,
		SEL_CTRL   = 3'd4,
		SEL_ACK    = 3'd5,
		SEL_UNUSED = 3'd6,
		SEL_BANK   = 3'd7
	} reg_sel_t;

endpackage

// File: hdl/bsirq_cmd_if.sv
// Input channel: bus write or CPU tick, valid/ready handshake.
// Depends on bsirq_pkg.
interface bsirq_cmd_if;
	import bsirq_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output op, output address, output write_data,
		input ready);
	modport sink (input valid, input op, input address, input write_data,
		output ready);
endinterface

// File: hdl/bsirq_res_if.sv
// Result channel: window banks and interrupt line, valid/ready handshake.
// Depends on bsirq_pkg.
interface bsirq_res_if;
	import bsirq_pkg::*;

	logic              valid;
	logic              ready;
	logic [BANK_W-1:0] low_window_bank;
	logic [BANK_W-1:0] high_window_bank;
	logic              irq_line;

	modport source (output valid, output low_window_bank, output high_window_bank,
		output irq_line, input ready);
	modport sink (input valid, input low_window_bank, input high_window_bank,
		input irq_line, output ready);
endinterface

// File: hdl/bank_switch_cycle_irq_counter.sv
// Top level of the bank switch / cycle IRQ counter block.
// Depends on bsirq_pkg, bsirq_cmd_if and bsirq_res_if.
//
// Usage:
//   cmd carries one beat per item: a register write (op = 0, address, data)
//   or one CPU clock tick (op = 1). res returns one beat per item with both
//   16K window banks and the interrupt line, taken after the item is applied.
//   The cfg port (cfg_we, cfg_index, cfg_data) sets the board's bank mask and
//   offset; write it only while no item is in flight.
// Pipeline: an accepted beat lands in the input register and is applied to the
//   mapper state on the next edge at which the result register is free; its
//   result is offered in the result register right after that edge.
// Throughput: one item per cycle while res takes results, set by the
//   combinational state update between the input register and the result register.
// Reset: arst_n clears all mapper state and the valid bits of both pipeline
//   stages; the mask returns to all ones and the offset to zero.
// Stall: while res is held off, one more beat is accepted into the input
//   register; after that cmd.ready drops until the result is taken.
module bank_switch_cycle_irq_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsirq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsirq_pkg::CFG_DATA_W-1:0] cfg_data,
	bsirq_cmd_if.sink                     cmd,
	bsirq_res_if.source                   res
);
	import bsirq_pkg::*;

	// configuration
	logic [BANK_W-1:0] bank_and_mask_q;
	logic [BANK_W-1:0] bank_or_offset_q;

	// mapper state
	logic [BANK_W-1:0] program_bank_q;
	logic [CTL_W-1:0]  irq_control_q;
	logic [CNT_W-1:0]  irq_counter_q;
	logic [CNT_W-1:0]  reload_value_q;
	logic              irq_pending_q;

	// input stage
	logic              valid_s1;
	logic              op_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] data_s1;

	// result stage
	logic              valid_s2;
	logic [BANK_W-1:0] low_bank_s2;
	logic [BANK_W-1:0] high_bank_s2;
	logic              irq_s2;

	// next state
	logic [BANK_W-1:0] program_bank_d;
	logic [CTL_W-1:0]  irq_control_d;
	logic [CNT_W-1:0]  irq_counter_d;
	logic [CNT_W-1:0]  reload_value_d;
	logic              irq_pending_d;
	reg_sel_t          sel;
	logic [1:0]        nib;
	logic              at_terminal;
	logic              advance;

	// handshake: the input stage moves on when the result stage is free
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign res.valid            = valid_s2;
	assign res.low_window_bank  = low_bank_s2;
	assign res.high_window_bank = high_bank_s2;
	assign res.irq_line         = irq_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_and_mask_q  <= BANK_AND_MASK_RST;
			bank_or_offset_q <= BANK_OR_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BANK_AND_MASK:  bank_and_mask_q  <= cfg_data[BANK_W-1:0];
				CFG_BANK_OR_OFFSET: bank_or_offset_q <= cfg_data[BANK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1      <= cmd.op;
			address_s1 <= cmd.address;
			data_s1    <= cmd.write_data;
		end
	end

	// apply one item to the mapper state
	always_comb begin
		program_bank_d = program_bank_q;
		irq_control_d  = irq_control_q;
		irq_counter_d  = irq_counter_q;
		reload_value_d = reload_value_q;
		irq_pending_d  = irq_pending_q;
		sel            = reg_sel_t'(address_s1[14:12]);
		nib            = address_s1[13:12];
		at_terminal    = irq_control_q[CTL_BYTE_MODE] ?
			(irq_counter_q[7:0] == BYTE_TERMINAL) : (irq_counter_q == WORD_TERMINAL);

		if (op_s1 == OP_TICK) begin
			// count only while enabled; overflow reloads and raises the request
			if (irq_control_q[CTL_ENABLE]) begin
				if (at_terminal) begin
					irq_counter_d = reload_value_q;
					irq_pending_d = 1'b1;
				end else begin
					irq_counter_d = irq_counter_q + 1'b1;
				end
			end
		end else begin
			unique case (sel) inside
				SEL_NIB0, SEL_NIB1, SEL_NIB2, SEL_NIB3: begin
					reload_value_d[{nib, 2'b00} +: 4] = data_s1[3:0];
				end
				SEL_CTRL: begin
					irq_control_d = data_s1[CTL_W-1:0];
					if (data_s1[CTL_ENABLE]) begin
						irq_counter_d = reload_value_q;
					end
				end
				SEL_ACK: begin
					irq_control_d[CTL_ENABLE] = irq_control_q[CTL_ACK_ENABLE];
					irq_pending_d             = 1'b0;
				end
				SEL_BANK: begin
					program_bank_d = data_s1[BANK_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// mapper state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_bank_q <= '0;
			irq_control_q  <= '0;
			irq_counter_q  <= '0;
			reload_value_q <= '0;
			irq_pending_q  <= 1'b0;
		end else if (advance) begin
			program_bank_q <= program_bank_d;
			irq_control_q  <= irq_control_d;
			irq_counter_q  <= irq_counter_d;
			reload_value_q <= reload_value_d;
			irq_pending_q  <= irq_pending_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			low_bank_s2  <= (program_bank_d & bank_and_mask_q) | bank_or_offset_q;
			high_bank_s2 <= (LAST_BANK & bank_and_mask_q) | bank_or_offset_q;
			irq_s2       <= irq_pending_d;
		end
	end

endmodule

// File: sim/testbench.sv
// Self-checking bench for bank_switch_cycle_irq_counter: directed and random mapper beats.
// An in-order predictor checks every result beat. Depends on bsirq_pkg, bsirq_cmd_if,
// bsirq_res_if and the top level of the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bsirq_pkg::*;

	localparam int CLK_PERIOD       = 20;
	localparam int RESET_CYCLES     = 12;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int DRAIN_CYCLES     = 6;
	localparam int RANDOM_PER_PHASE = 80;
	localparam int RANDOM_PHASES    = 6;
	localparam int MAX_REPORTS      = 10;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} mapper_cmd_t;

	typedef struct packed {
		logic [BANK_W-1:0] low_bank;
		logic [BANK_W-1:0] high_bank;
		logic              irq;
	} window_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsirq_cmd_if cmd_ch ();
	bsirq_res_if res_ch ();

	bank_switch_cycle_irq_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Pending command beats and the window results they are due to produce
	mapper_cmd_t  cmd_pending [$];
	window_beat_t window_due [$];
	mapper_cmd_t  next_cmd;
	window_beat_t due_beat;

	// Shadow copy of the mapper state and board configuration
	logic [BANK_W-1:0] shadow_bank;
	logic [CTL_W-1:0]  shadow_ctl;
	logic [CNT_W-1:0]  shadow_count;
	logic [CNT_W-1:0]  shadow_reload;
	logic              shadow_pending;
	logic [BANK_W-1:0] shadow_mask;
	logic [BANK_W-1:0] shadow_offset;

	bit          tx_idle_en;
	bit          rx_idle_en;
	int unsigned tx_hold;
	int unsigned rx_hold;
	int          fail_count;
	int          quiet_cycles;
	int          queued_items;

	// Apply one command beat to the shadow state and return the window it yields
	function automatic window_beat_t predict_window(logic op, logic [ADDR_W-1:0] address,
			logic [DATA_W-1:0] data);
		reg_sel_t     sel;
		logic         at_terminal;
		window_beat_t beat;
		sel = reg_sel_t'(address[14:12]);
		if (op == OP_TICK) begin
			if (shadow_ctl[CTL_ENABLE]) begin
				if (shadow_ctl[CTL_BYTE_MODE])
					at_terminal = (shadow_count[7:0] == BYTE_TERMINAL);
				else
					at_terminal = (shadow_count == WORD_TERMINAL);
				if (at_terminal) begin
					shadow_count   = shadow_reload;
					shadow_pending = 1'b1;
				end else begin
					shadow_count = shadow_count + 1'b1;
				end
			end
		end else begin
			case (sel) inside
				SEL_NIB0, SEL_NIB1, SEL_NIB2, SEL_NIB3: begin
					shadow_reload[{address[13:12], 2'b00} +: 4] = data[3:0];
				end
				SEL_CTRL: begin
					shadow_ctl = data[CTL_W-1:0];
					if (shadow_ctl[CTL_ENABLE])
						shadow_count = shadow_reload;
				end
				SEL_ACK: begin
					shadow_ctl[CTL_ENABLE] = shadow_ctl[CTL_ACK_ENABLE];
					shadow_pending         = 1'b0;
				end
				SEL_BANK: begin
					shadow_bank = data;
				end
				default: begin
				end
			endcase
		end
		beat.low_bank  = (shadow_bank & shadow_mask) | shadow_offset;
		beat.high_bank = (LAST_BANK & shadow_mask) | shadow_offset;
		beat.irq       = shadow_pending;
		return beat;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!enabled || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_item(logic op, logic [ADDR_W-1:0] address, logic [DATA_W-1:0] data);
		mapper_cmd_t item;
		item.op         = op;
		item.address    = address;
		item.write_data = data;
		cmd_pending.push_back(item);
		queued_items++;
	endtask

	// Register write with random mirror bit 15 and random don't-care low bits
	task automatic queue_write(reg_sel_t sel, logic [DATA_W-1:0] data);
		queue_item(OP_WRITE, {1'($urandom), sel, 12'($urandom)}, data);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		if (index == CFG_BANK_AND_MASK)
			shadow_mask = value;
		else
			shadow_offset = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the sender off until every due result has been taken
	task automatic wait_drained();
		while (cmd_pending.size() != 0 || cmd_ch.valid || window_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Command driver: one beat offered at a time, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid      <= 1'b0;
			cmd_ch.op         <= OP_WRITE;
			cmd_ch.address    <= '0;
			cmd_ch.write_data <= '0;
			tx_hold           <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				window_due.push_back(predict_window(cmd_ch.op, cmd_ch.address,
					cmd_ch.write_data));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (tx_hold != 0) begin
					cmd_ch.valid <= 1'b0;
					tx_hold      <= tx_hold - 1;
				end else if (cmd_pending.size() != 0) begin
					next_cmd          = cmd_pending.pop_front();
					cmd_ch.op         <= next_cmd.op;
					cmd_ch.address    <= next_cmd.address;
					cmd_ch.write_data <= next_cmd.write_data;
					cmd_ch.valid      <= 1'b1;
					tx_hold           <= pick_gap(tx_idle_en);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random back-pressure, compare each beat with the oldest due one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_hold      <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (window_due.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("unexpected result beat: low %02h high %02h irq %b",
							res_ch.low_window_bank, res_ch.high_window_bank, res_ch.irq_line);
					fail_count++;
				end else begin
					due_beat = window_due.pop_front();
					if (res_ch.low_window_bank !== due_beat.low_bank
							|| res_ch.high_window_bank !== due_beat.high_bank
							|| res_ch.irq_line !== due_beat.irq) begin
						if (fail_count < MAX_REPORTS)
							$display("mismatch at %0t: low %02h/%02h high %02h/%02h irq %b/%b (exp/act)",
								$realtime, due_beat.low_bank, res_ch.low_window_bank,
								due_beat.high_bank, res_ch.high_window_bank,
								due_beat.irq, res_ch.irq_line);
						fail_count++;
					end
				end
			end
			if (rx_hold != 0) begin
				res_ch.ready <= 1'b0;
				rx_hold      <= rx_hold - 1;
			end else begin
				res_ch.ready <= 1'b1;
				rx_hold      <= pick_gap(rx_idle_en);
			end
		end
	end

	// Count cycles with no beat on either channel and no config write
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus: directed sequence, then random phases under several board settings
	initial begin
		int unsigned    roll;
		int unsigned    run_len;
		logic [CNT_W-1:0] reload;
		logic [DATA_W-1:0] ctl;
		logic [BANK_W-1:0] mask;
		logic [BANK_W-1:0] offset;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = OP_WRITE;
		cmd_ch.address    = '0;
		cmd_ch.write_data = '0;
		res_ch.ready      = 1'b0;
		fail_count        = 0;
		quiet_cycles      = 0;
		queued_items      = 0;
		tx_idle_en        = 1'b1;
		rx_idle_en        = 1'b1;
		shadow_bank       = '0;
		shadow_ctl        = '0;
		shadow_count      = '0;
		shadow_reload     = '0;
		shadow_pending    = 1'b0;
		shadow_mask       = BANK_AND_MASK_RST;
		shadow_offset     = BANK_OR_OFFSET_RST;

		// Bank select extremes, including the mirror below 0x8000
		queue_item(OP_WRITE, 16'hF000, 8'h00);
		queue_item(OP_WRITE, 16'h7FFF, 8'hFF);
		queue_item(OP_WRITE, 16'hF5A5, 8'hA5);
		// Reload = 0xFFFD one nibble at a time, upper data bits ignored
		queue_item(OP_WRITE, 16'h8000, 8'h0D);
		queue_item(OP_WRITE, 16'h9FFF, 8'hFF);
		queue_item(OP_WRITE, 16'hA000, 8'hFF);
		queue_item(OP_WRITE, 16'h3ABC, 8'hFF);
		// Word mode, enable and enable-after-ack: count up through overflow
		queue_item(OP_WRITE, 16'hC000, 8'h03);
		queue_item(OP_TICK, 16'h0000, 8'h00);
		queue_item(OP_TICK, 16'hFFFF, 8'hFF);
		queue_item(OP_TICK, 16'h8000, 8'h5A);
		queue_item(OP_TICK, 16'h7123, 8'hA5);
		// Ack keeps the counter enabled
		queue_item(OP_WRITE, 16'hD000, 8'hFF);
		// Byte mode: overflow on low byte, then again while already pending
		queue_item(OP_WRITE, 16'hC000, 8'h07);
		repeat (6) queue_item(OP_TICK, 16'($urandom), 8'($urandom));
		// Ack without enable-after-ack stops the counter
		queue_item(OP_WRITE, 16'hC000, 8'h06);
		queue_item(OP_WRITE, 16'hD000, 8'h00);
		queue_item(OP_TICK, 16'hFFFF, 8'h00);
		// Unused select, then control with only ignored bits set
		queue_item(OP_WRITE, 16'hE000, 8'hFF);
		queue_item(OP_WRITE, 16'h6FFF, 8'h00);
		queue_item(OP_WRITE, 16'hC000, 8'hF8);
		queue_item(OP_TICK, 16'h0000, 8'hFF);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin mask = 8'h00; offset = 8'h00; end
				1: begin mask = 8'hFF; offset = 8'hFF; end
				2: begin mask = 8'h00; offset = 8'hFF; end
				3: begin mask = 8'h0F; offset = 8'hA0; end
				4: begin mask = 8'($urandom); offset = 8'($urandom); end
				default: begin mask = BANK_AND_MASK_RST; offset = BANK_OR_OFFSET_RST; end
			endcase
			write_cfg(CFG_BANK_AND_MASK, mask);
			write_cfg(CFG_BANK_OR_OFFSET, offset);
			tx_idle_en = (phase != 0) && (phase != 3);
			rx_idle_en = (phase != 0);

			queued_items = 0;
			while (queued_items < RANDOM_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					// Program a reload value, mostly near the terminal count, set control, then run ticks
					reload = 16'($urandom);
					if ($urandom_range(0, 3) != 0)
						reload[15:6] = '1;
					for (int n = 0; n < 4; n++)
						if ($urandom_range(0, 7) != 0)
							queue_write(reg_sel_t'(n), {4'($urandom), reload[4*n +: 4]});
					ctl = 8'($urandom);
					if ($urandom_range(0, 4) != 0)
						ctl[CTL_ENABLE] = 1'b1;
					queue_write(SEL_CTRL, ctl);
					run_len = $urandom_range(1, 70);
					repeat (run_len) begin
						roll = $urandom_range(0, 99);
						if (roll < 6)
							queue_write(SEL_ACK, 8'($urandom));
						else if (roll < 9)
							queue_write(SEL_BANK, 8'($urandom));
						else if (roll < 10)
							queue_write(SEL_UNUSED, 8'($urandom));
						else
							queue_item(OP_TICK, 16'($urandom), 8'($urandom));
					end
					if ($urandom_range(0, 1) != 0)
						queue_write(SEL_ACK, 8'($urandom));
				end else if (roll < 85) begin
					queue_write((roll < 78) ? SEL_BANK : SEL_ACK, 8'($urandom));
				end else begin
					// Noise: any op, any address, any data
					repeat ($urandom_range(1, 5))
						queue_item(1'($urandom), 16'($urandom), 8'($urandom));
				end
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: bank_switch_cycle_irq_counter.f
hdl/bsirq_pkg.sv
hdl/bsirq_cmd_if.sv
hdl/bsirq_res_if.sv
hdl/bank_switch_cycle_irq_counter.sv
sim/testbench.sv
